>>> rtl/sks_pkg.sv
`default_nettype none
package sks_pkg;

	// Table geometry; slot selection takes the low hash bits, so CAPACITY is a power of two
	localparam int CAPACITY = 1024;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 128;
	localparam int VAL_W    = 32;

	localparam logic [63:0] HASH_GOLDEN = 64'h0000_0000_9e37_79b9;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_ERASE  = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MARK_EMPTY = 2'd0,
		MARK_LIVE  = 2'd1,
		MARK_TOMB  = 2'd2
	} mark_t;

	typedef struct packed {
		cmd_t               command;
		logic signed [31:0] coord_a;
		logic signed [31:0] coord_b;
		logic signed [31:0] coord_c;
		logic signed [31:0] coord_d;
		logic signed [31:0] write_value;
	} in_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic               found;
		logic [10:0]        entry_count;
		logic               status;
	} out_t;

	// Write request into the slot memories
	typedef struct packed {
		logic             kd_we;
		logic             key_we;
		logic [IDX_W-1:0] kd_addr;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] data;
		logic             mark_we;
		logic [IDX_W-1:0] mark_addr;
		mark_t            mark;
	} slot_wr_t;

	// Registered read data of one slot
	typedef struct packed {
		mark_t            mark;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] data;
	} slot_rd_t;

endpackage
`default_nettype wire

>>> rtl/sks_hash_unit.sv
`default_nettype none
module sks_hash_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [sks_pkg::KEY_W-1:0]     key,
	output logic                               done,
	output logic [sks_pkg::IDX_W-1:0]          home
);

	logic [63:0] seed_q;
	logic [1:0]  step_q;
	logic        run_q;
	logic        done_q;
	logic [31:0] coord;
	logic [63:0] coord_ext;
	logic [63:0] mix;

	// Pick one coordinate per step, a first
	always_comb begin
		case (step_q)
			2'd0:    coord = key[127:96];
			2'd1:    coord = key[95:64];
			2'd2:    coord = key[63:32];
			default: coord = key[31:0];
		endcase
		coord_ext = {{32{coord[31]}}, coord};
		mix = seed_q ^ (coord_ext + sks_pkg::HASH_GOLDEN + (seed_q << 6) + (seed_q >> 2));
	end

	// Fold one coordinate into the seed per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			step_q <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				seed_q <= '0;
				step_q <= '0;
				run_q  <= 1'b1;
			end else if (run_q) begin
				seed_q <= mix;
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign home = seed_q[sks_pkg::IDX_W-1:0];

endmodule
`default_nettype wire

>>> rtl/sks_slot_mem.sv
`default_nettype none
module sks_slot_mem (
	input  wire logic                       clk,
	input  wire logic [sks_pkg::IDX_W-1:0]  rd_addr,
	input  wire sks_pkg::slot_wr_t          wr,
	output sks_pkg::slot_rd_t               rd
);

	logic [sks_pkg::KEY_W-1:0] key_mem  [sks_pkg::CAPACITY];
	logic [sks_pkg::VAL_W-1:0] data_mem [sks_pkg::CAPACITY];
	sks_pkg::mark_t            mark_mem [sks_pkg::CAPACITY];
	sks_pkg::slot_rd_t         rd_q;

	// Write ports
	always_ff @(posedge clk) begin
		if (wr.key_we) begin
			key_mem[wr.kd_addr] <= wr.key;
		end
		if (wr.kd_we) begin
			data_mem[wr.kd_addr] <= wr.data;
		end
		if (wr.mark_we) begin
			mark_mem[wr.mark_addr] <= wr.mark;
		end
	end

	// Registered read of one slot
	always_ff @(posedge clk) begin
		rd_q.mark <= mark_mem[rd_addr];
		rd_q.key  <= key_mem[rd_addr];
		rd_q.data <= data_mem[rd_addr];
	end

	assign rd = rd_q;

endmodule
`default_nettype wire

>>> rtl/sparse_4d_keyed_store_core.sv
`default_nettype none
// Sparse store of 32-bit values keyed by four signed 32-bit coordinates.
// Input channel in_valid/in_stall/in_data carries one command transaction
// (insert, lookup, erase, clear); each produces exactly one result on
// out_valid/out_stall/out_data with the lookup value, found flag, live entry
// count and full-table status. cfg_wr_en/cfg_wr_data write the default value.
// A command is hashed one coordinate per cycle through the mix unit, then
// each probed slot takes a registered slot memory read, then a compare;
// then the table is updated and the result posted. At an empty table a
// single probe suffices. A clear sweeps the slot marks one per cycle.
// in_stall is high while a command is in work. The result sits in an output
// register, so the next command is accepted while it waits; a command that
// finishes while the receiver still stalls waits for the register to free.
// After reset the block runs a clearing pass over the slot marks with
// in_stall high; configuration writes are taken meanwhile.
module sparse_4d_keyed_store_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire sks_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_stall,
	output sks_pkg::out_t      out_data,
	input  wire logic          cfg_wr_en,
	input  wire logic [31:0]   cfg_wr_data
);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_HASH,
		S_READ,
		S_CMP,
		S_WRITE,
		S_DONE,
		S_CLEAR
	} state_t;

	state_t                        state_q;
	sks_pkg::in_t                  item_q;
	logic signed [31:0]            default_q;
	logic [sks_pkg::IDX_W-1:0]     pos_q;
	logic [sks_pkg::IDX_W-1:0]     free_q;
	logic [sks_pkg::IDX_W-1:0]     clr_q;
	logic [sks_pkg::CNT_W-1:0]     n_q;
	logic [sks_pkg::CNT_W-1:0]     live_count_q;
	logic                          have_free_q;
	logic                          found_q;
	logic [31:0]                   hit_data_q;
	sks_pkg::out_t                 res_q;
	sks_pkg::out_t                 out_q;
	logic                          out_valid_q;

	logic                          accept;
	logic                          hash_start;
	logic                          hash_done;
	logic [sks_pkg::IDX_W-1:0]     hash_home;
	logic [sks_pkg::KEY_W-1:0]     item_key;
	logic                          key_match;
	logic [sks_pkg::IDX_W-1:0]     pos_next;
	logic                          last_probe;
	logic                          last_clr;
	logic                          out_load;
	sks_pkg::slot_wr_t             wr;
	sks_pkg::slot_rd_t             rd;
	logic [sks_pkg::CNT_W-1:0]     count_next;
	sks_pkg::out_t                 res_next;

	assign accept     = in_valid && !in_stall;
	assign hash_start = accept && (in_data.command != sks_pkg::CMD_CLEAR);
	assign item_key   = {item_q.coord_a, item_q.coord_b, item_q.coord_c, item_q.coord_d};
	assign key_match  = (rd.key == item_key);
	assign pos_next   = (pos_q == sks_pkg::IDX_W'(sks_pkg::CAPACITY - 1)) ? '0 :
	                    pos_q + sks_pkg::IDX_W'(1);
	assign last_probe = (n_q == sks_pkg::CNT_W'(sks_pkg::CAPACITY - 1));
	assign last_clr   = (clr_q == sks_pkg::IDX_W'(sks_pkg::CAPACITY - 1));
	assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	sks_hash_unit u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (item_key),
		.done   (hash_done),
		.home   (hash_home)
	);

	sks_slot_mem u_mem (
		.clk     (clk),
		.rd_addr (pos_q),
		.wr      (wr),
		.rd      (rd)
	);

	// Mark writes of the clearing sweep, and table update and result for the command that finished probing
	always_comb begin
		wr                   = '0;
		wr.kd_addr           = found_q ? pos_q : free_q;
		wr.key               = item_key;
		wr.data              = item_q.write_value;
		wr.mark_addr         = pos_q;
		wr.mark              = sks_pkg::MARK_EMPTY;
		count_next           = live_count_q;
		res_next             = '0;
		res_next.found       = found_q;
		if (state_q == S_INIT || state_q == S_CLEAR) begin
			wr.mark_we   = 1'b1;
			wr.mark_addr = clr_q;
		end else if (state_q == S_WRITE) begin
			case (item_q.command)
				sks_pkg::CMD_INSERT: begin
					if (item_q.write_value != default_q) begin
						if (found_q) begin
							wr.kd_we = 1'b1;
						end else if (have_free_q) begin
							wr.kd_we     = 1'b1;
							wr.key_we    = 1'b1;
							wr.mark_we   = 1'b1;
							wr.mark_addr = free_q;
							wr.mark      = sks_pkg::MARK_LIVE;
							count_next   = live_count_q + sks_pkg::CNT_W'(1);
						end else begin
							res_next.status = 1'b1;
						end
					end
				end
				sks_pkg::CMD_LOOKUP: begin
					res_next.read_value = found_q ? hit_data_q : default_q;
				end
				sks_pkg::CMD_ERASE: begin
					if (found_q) begin
						wr.mark_we = 1'b1;
						wr.mark    = sks_pkg::MARK_TOMB;
						if (live_count_q != '0) begin
							count_next = live_count_q - sks_pkg::CNT_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
		res_next.entry_count = 11'(count_next);
	end

	// Hold the default value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_q <= '0;
		end else if (cfg_wr_en) begin
			default_q <= cfg_wr_data;
		end
	end

	// Sequencer: hash, probe, update, post result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			item_q       <= '0;
			pos_q        <= '0;
			free_q       <= '0;
			clr_q        <= '0;
			n_q          <= '0;
			live_count_q <= '0;
			have_free_q  <= 1'b0;
			found_q      <= 1'b0;
			hit_data_q   <= '0;
			res_q        <= '0;
			out_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// Load the output register, or drop it once taken
			if (out_load) begin
				out_q       <= res_q;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT, S_CLEAR: begin
					if (last_clr) begin
						clr_q        <= '0;
						live_count_q <= '0;
						res_q        <= '0;
						state_q      <= (state_q == S_INIT) ? S_IDLE : S_DONE;
					end else begin
						clr_q <= clr_q + sks_pkg::IDX_W'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						item_q  <= in_data;
						clr_q   <= '0;
						state_q <= (in_data.command == sks_pkg::CMD_CLEAR) ? S_CLEAR : S_HASH;
					end
				end
				S_HASH: begin
					if (hash_done) begin
						pos_q       <= hash_home;
						n_q         <= '0;
						found_q     <= 1'b0;
						have_free_q <= 1'b0;
						state_q     <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (rd.mark == sks_pkg::MARK_EMPTY) begin
						if (!have_free_q) begin
							have_free_q <= 1'b1;
							free_q      <= pos_q;
						end
						state_q <= S_WRITE;
					end else if (rd.mark == sks_pkg::MARK_LIVE && key_match) begin
						found_q    <= 1'b1;
						hit_data_q <= rd.data;
						state_q    <= S_WRITE;
					end else begin
						if (rd.mark != sks_pkg::MARK_LIVE && !have_free_q) begin
							have_free_q <= 1'b1;
							free_q      <= pos_q;
						end
						if (last_probe) begin
							state_q <= S_WRITE;
						end else begin
							n_q     <= n_q + sks_pkg::CNT_W'(1);
							pos_q   <= pos_next;
							state_q <= S_READ;
						end
					end
				end
				S_WRITE: begin
					live_count_q <= count_next;
					res_q        <= res_next;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Live count never exceeds the table size
	assert property (@(posedge clk) disable iff (!arst_n)
		live_count_q <= sks_pkg::CNT_W'(sks_pkg::CAPACITY))
		else $error("live count above capacity");

	// A rejected insert happens only with every slot live
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status |->
		out_data.entry_count == 11'(sks_pkg::CAPACITY))
		else $error("insert rejected while table not full");

	// A hit never comes with a rejection
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.found && out_data.status))
		else $error("found and rejected in one result");

	// Hash completes only while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		hash_done |-> state_q == S_HASH)
		else $error("hash done outside hash state");

endmodule
`default_nettype wire

>>> sim/tb_sparse_4d_keyed_store_core.sv
`timescale 1ns / 1ps

module tb_sparse_4d_keyed_store_core;

	// Generous bound: about 1300 transactions, each allowed a full-table probe
	// plus receiver stalls, several times over, and the clearing pass after reset
	localparam int CYCLE_LIMIT = 16_000_000;
	localparam int MAX_PRINTS  = 50;
	localparam int KEY_POOL    = 48;
	localparam int RAND_ITEMS  = 50;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	sks_pkg::in_t  in_data;
	logic out_valid;
	logic out_stall;
	sks_pkg::out_t out_data;
	logic cfg_wr_en;
	logic [31:0] cfg_wr_data;

	// Shadow copy of the table and the default register
	logic [sks_pkg::KEY_W-1:0] tbl_key  [sks_pkg::CAPACITY];
	logic [31:0]               tbl_data [sks_pkg::CAPACITY];
	sks_pkg::mark_t            tbl_mark [sks_pkg::CAPACITY];
	int unsigned               tbl_live;
	logic [31:0]               dflt_value;

	sks_pkg::out_t pending_results [$];
	int   mismatch_count;
	int   cycle_count;
	int   send_idle_pct;
	int   recv_stall_pct;

	sparse_4d_keyed_store_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Fold one sign-extended coordinate into the running hash
	function automatic logic [63:0] hash_fold(logic [63:0] seed, logic [31:0] coord);
		logic [63:0] wide;
		wide = {{32{coord[31]}}, coord};
		return seed ^ (wide + sks_pkg::HASH_GOLDEN + (seed << 6) + (seed >> 2));
	endfunction

	// Apply one command to the shadow table and return the result it must give
	function automatic sks_pkg::out_t predict_store(sks_pkg::in_t item);
		sks_pkg::out_t             res;
		logic [63:0]               seed;
		logic [sks_pkg::KEY_W-1:0] key;
		logic [sks_pkg::IDX_W-1:0] pos;
		logic [sks_pkg::IDX_W-1:0] hit_pos;
		logic [sks_pkg::IDX_W-1:0] free_pos;
		bit                        hit;
		bit                        have_free;
		res = '0;
		hit = 1'b0;
		have_free = 1'b0;
		hit_pos = '0;
		free_pos = '0;
		if (item.command == sks_pkg::CMD_CLEAR) begin
			foreach (tbl_mark[i]) tbl_mark[i] = sks_pkg::MARK_EMPTY;
			tbl_live = 0;
		end else begin
			key = {item.coord_a, item.coord_b, item.coord_c, item.coord_d};
			seed = '0;
			seed = hash_fold(seed, item.coord_a);
			seed = hash_fold(seed, item.coord_b);
			seed = hash_fold(seed, item.coord_c);
			seed = hash_fold(seed, item.coord_d);
			pos = seed[sks_pkg::IDX_W-1:0];
			// Probe linearly until a match, an empty slot or one full lap
			for (int n = 0; n < sks_pkg::CAPACITY; n++) begin
				if (tbl_mark[pos] == sks_pkg::MARK_EMPTY) begin
					if (!have_free) begin
						have_free = 1'b1;
						free_pos = pos;
					end
					break;
				end
				if (tbl_mark[pos] == sks_pkg::MARK_LIVE) begin
					if (tbl_key[pos] == key) begin
						hit = 1'b1;
						hit_pos = pos;
						break;
					end
				end else if (!have_free) begin
					have_free = 1'b1;
					free_pos = pos;
				end
				pos = pos + 1'b1;
			end
			case (item.command)
				sks_pkg::CMD_INSERT: begin
					if (item.write_value != dflt_value) begin
						if (hit) begin
							tbl_data[hit_pos] = item.write_value;
						end else if (have_free) begin
							tbl_key[free_pos] = key;
							tbl_data[free_pos] = item.write_value;
							tbl_mark[free_pos] = sks_pkg::MARK_LIVE;
							tbl_live++;
						end else begin
							res.status = 1'b1;
						end
					end
				end
				sks_pkg::CMD_LOOKUP: begin
					res.read_value = hit ? tbl_data[hit_pos] : dflt_value;
				end
				default: begin
					if (hit) begin
						tbl_mark[hit_pos] = sks_pkg::MARK_TOMB;
						if (tbl_live > 0) tbl_live--;
					end
				end
			endcase
		end
		res.found = hit;
		res.entry_count = tbl_live[10:0];
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatch_count < MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Check each accepted result against the oldest expectation
	always @(posedge clk) begin : check_results
		sks_pkg::out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result transaction with nothing pending");
			end else begin
				want = pending_results.pop_front();
				if (out_data.read_value !== want.read_value)
					report_mismatch($sformatf("read_value got %h expected %h",
						out_data.read_value, want.read_value));
				if (out_data.found !== want.found)
					report_mismatch($sformatf("found got %b expected %b",
						out_data.found, want.found));
				if (out_data.entry_count !== want.entry_count)
					report_mismatch($sformatf("entry_count got %0d expected %0d",
						out_data.entry_count, want.entry_count));
				if (out_data.status !== want.status)
					report_mismatch($sformatf("status got %b expected %b",
						out_data.status, want.status));
			end
		end
	end

	// Stall the result channel at random
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sparse_4d_keyed_store_core test failed");
			$finish;
		end
	end

	function automatic sks_pkg::in_t make_item(sks_pkg::cmd_t cmd,
		logic [sks_pkg::KEY_W-1:0] key, logic [31:0] value);
		sks_pkg::in_t item;
		item.command = cmd;
		item.coord_a = key[127:96];
		item.coord_b = key[95:64];
		item.coord_c = key[63:32];
		item.coord_d = key[31:0];
		item.write_value = value;
		return item;
	endfunction

	// Coordinates lean toward the extremes now and then
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(15))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [sks_pkg::KEY_W-1:0] rand_key();
		return {rand_coord(), rand_coord(), rand_coord(), rand_coord()};
	endfunction

	// Offer one transaction, hold it until accepted, then record its result
	task automatic send_cmd(sks_pkg::in_t item);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(predict_store(item));
	endtask

	// Drop valid and wait for every outstanding result
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_default(logic [31:0] value);
		drain_results();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		dflt_value = value;
	endtask

	localparam logic [sks_pkg::KEY_W-1:0] KEY_MIN   = {4{32'h8000_0000}};
	localparam logic [sks_pkg::KEY_W-1:0] KEY_MAX   = {4{32'h7fff_ffff}};
	localparam logic [sks_pkg::KEY_W-1:0] KEY_ZERO  = '0;
	localparam logic [sks_pkg::KEY_W-1:0] KEY_ONES  = '1;
	localparam logic [sks_pkg::KEY_W-1:0] KEY_MIXED = {32'h8000_0000, 32'h7fff_ffff,
		32'h0000_0000, 32'hffff_ffff};

	// Insert, lookup, overwrite and erase with extreme keys and values
	task automatic test_basic_ops();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_default(32'h0000_0000);
		send_cmd(make_item(sks_pkg::CMD_INSERT, KEY_MIN, 32'h7fff_ffff));
		send_cmd(make_item(sks_pkg::CMD_INSERT, KEY_MAX, 32'h8000_0000));
		send_cmd(make_item(sks_pkg::CMD_INSERT, KEY_ZERO, 32'h0000_0001));
		send_cmd(make_item(sks_pkg::CMD_INSERT, KEY_MIXED, 32'hffff_ffff));
		send_cmd(make_item(sks_pkg::CMD_LOOKUP, KEY_MIN, '0));
		send_cmd(make_item(sks_pkg::CMD_LOOKUP, KEY_MAX, '0));
		send_cmd(make_item(sks_pkg::CMD_LOOKUP, KEY_ZERO, '1));
		send_cmd(make_item(sks_pkg::CMD_LOOKUP, KEY_MIXED, '0));
		send_cmd(make_item(sks_pkg::CMD_LOOKUP, KEY_ONES, '0));
		send_cmd(make_item(sks_pkg::CMD_INSERT, KEY_MIN, 32'h1234_5678));
		send_cmd(make_item(sks_pkg::CMD_LOOKUP, KEY_MIN, '0));
		send_cmd(make_item(sks_pkg::CMD_ERASE, KEY_MAX, '0));
		send_cmd(make_item(sks_pkg::CMD_LOOKUP, KEY_MAX, '0));
		// Erase of a key that is gone leaves the table alone
		send_cmd(make_item(sks_pkg::CMD_ERASE, KEY_MAX, '0));
		send_cmd(make_item(sks_pkg::CMD_INSERT, KEY_MAX, 32'h0000_0005));
		send_cmd(make_item(sks_pkg::CMD_LOOKUP, KEY_MAX, '0));
	endtask

	// Inserts of the default value change nothing; absent keys read the default
	task automatic test_default_value();
		write_default(32'h7fff_ffff);
		send_cmd(make_item(sks_pkg::CMD_INSERT, KEY_ONES, 32'h7fff_ffff));
		send_cmd(make_item(sks_pkg::CMD_LOOKUP, KEY_ONES, '0));
		send_cmd(make_item(sks_pkg::CMD_INSERT, KEY_ZERO, 32'h7fff_ffff));
		send_cmd(make_item(sks_pkg::CMD_LOOKUP, KEY_ZERO, '0));
		write_default(32'h8000_0000);
		send_cmd(make_item(sks_pkg::CMD_LOOKUP, KEY_ONES, '0));
		write_default(32'h0000_0000);
	endtask

	task automatic test_clear();
		send_cmd(make_item(sks_pkg::CMD_CLEAR, KEY_ONES, '1));
		send_cmd(make_item(sks_pkg::CMD_LOOKUP, KEY_MIN, '0));
		send_cmd(make_item(sks_pkg::CMD_INSERT, KEY_MIN, 32'h0000_0009));
		send_cmd(make_item(sks_pkg::CMD_ERASE, KEY_MIN, '0));
		send_cmd(make_item(sks_pkg::CMD_LOOKUP, KEY_MIN, '0));
	endtask

	// Fill every slot, then probe the full table and reuse a tombstone
	task automatic test_table_full();
		logic [31:0] base_a;
		logic [95:0] tail;
		logic [31:0] spare;
		base_a = $urandom;
		tail = {$urandom, $urandom, $urandom};
		write_default($urandom);
		spare = dflt_value ^ 32'h5a5a_5a5a;
		send_cmd(make_item(sks_pkg::CMD_CLEAR, '0, '0));
		for (int i = 0; i < sks_pkg::CAPACITY; i++)
			send_cmd(make_item(sks_pkg::CMD_INSERT, {base_a + 32'(i), tail},
				dflt_value ^ 32'(i + 1)));
		send_cmd(make_item(sks_pkg::CMD_INSERT,
			{base_a + 32'(sks_pkg::CAPACITY), tail}, spare));
		send_cmd(make_item(sks_pkg::CMD_INSERT,
			{base_a + 32'(sks_pkg::CAPACITY), tail}, dflt_value));
		send_cmd(make_item(sks_pkg::CMD_LOOKUP,
			{base_a + 32'(sks_pkg::CAPACITY), tail}, '0));
		send_cmd(make_item(sks_pkg::CMD_INSERT, {base_a + 32'd5, tail}, spare));
		send_cmd(make_item(sks_pkg::CMD_LOOKUP, {base_a + 32'd5, tail}, '0));
		send_cmd(make_item(sks_pkg::CMD_ERASE, {base_a + 32'd7, tail}, '0));
		send_cmd(make_item(sks_pkg::CMD_LOOKUP,
			{base_a + 32'(sks_pkg::CAPACITY), tail}, '0));
		send_cmd(make_item(sks_pkg::CMD_INSERT,
			{base_a + 32'(sks_pkg::CAPACITY), tail}, spare));
		send_cmd(make_item(sks_pkg::CMD_INSERT,
			{base_a + 32'(sks_pkg::CAPACITY + 1), tail}, spare));
		send_cmd(make_item(sks_pkg::CMD_LOOKUP,
			{base_a + 32'(sks_pkg::CAPACITY), tail}, '0));
		send_cmd(make_item(sks_pkg::CMD_CLEAR, '0, '0));
	endtask

	// Mostly commands on a small key pool, with fresh keys and clears as noise
	task automatic test_random(int idle_pct, int stall_pct, logic [31:0] dflt);
		logic [sks_pkg::KEY_W-1:0] key_pool [KEY_POOL];
		logic [sks_pkg::KEY_W-1:0] key;
		logic [31:0]               value;
		sks_pkg::cmd_t             cmd;
		int                        pick;
		write_default(dflt);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		foreach (key_pool[i]) key_pool[i] = rand_key();
		send_cmd(make_item(sks_pkg::CMD_CLEAR, rand_key(), $urandom));
		for (int i = 0; i < RAND_ITEMS; i++) begin
			pick = $urandom_range(99);
			if (pick < 40) cmd = sks_pkg::CMD_INSERT;
			else if (pick < 75) cmd = sks_pkg::CMD_LOOKUP;
			else if (pick < 98) cmd = sks_pkg::CMD_ERASE;
			else cmd = sks_pkg::CMD_CLEAR;
			key = ($urandom_range(9) == 0) ? rand_key() : key_pool[$urandom_range(KEY_POOL - 1)];
			value = ($urandom_range(6) == 0) ? dflt_value : $urandom;
			send_cmd(make_item(cmd, key, value));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		tbl_live = 0;
		dflt_value = '0;
		foreach (tbl_mark[i]) tbl_mark[i] = sks_pkg::MARK_EMPTY;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_basic_ops();
		test_default_value();
		test_clear();
		test_table_full();
		test_random(0, 0, 32'h8000_0000);
		test_random(48, 0, 32'h7fff_ffff);
		test_random(0, 48, $urandom);
		test_random(28, 28, 32'hffff_ffff);

		// Let the last results land, then settle
		drain_results();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("sparse_4d_keyed_store_core test passed");
		end else begin
			$display("sparse_4d_keyed_store_core test failed");
		end
		$finish;
	end

endmodule
